>>> hw/rtl/bffa_pkg.sv
`default_nettype none
package bffa_pkg;

  localparam int MEMORY_UNITS = 4096;

  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WORDS     = (MEMORY_UNITS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int AW        = WADDR_W + 1;
  localparam int LOG_UNITS = $clog2(MEMORY_UNITS);

  localparam int LEN_W  = 8;
  localparam int BASE_W = 12;
  localparam int UW     = ((LOG_UNITS > BASE_W) ? LOG_UNITS : BASE_W) + 1;
  localparam int RUN_W  = BIT_W + 1;
  localparam int TOT_W  = LEN_W + 1;

  localparam int BASE_WORDS = (1 << BASE_W) / WORD_W;
  localparam int LAST_BITS  = MEMORY_UNITS - (WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

  localparam logic [BASE_W-1:0] RESERVED_RESET = 12'd24;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_BAD_FREE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } fsm_t;

  typedef struct packed {
    logic          clear;
    logic          valid;
    logic [AW-1:0] word;
  } scan_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              last;
    logic [BASE_W-1:0] base;
  } scan_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/bffa_ram.sv
`default_nettype none
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/bffa_scan.sv
`default_nettype none
module bffa_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  bffa_pkg::scan_ctl_t                 ctl,
  input  logic [bffa_pkg::WORD_W-1:0]         data,
  input  logic [bffa_pkg::LEN_W-1:0]          len,
  input  logic [bffa_pkg::BASE_W-1:0]         rsv,
  output bffa_pkg::scan_res_t                 res
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] free_bits;
  logic [RUN_W-1:0]  zpos     [WORD_W];
  logic [RUN_W-1:0]  run_next [WORD_W];

  logic              s1_v;
  logic [AW-1:0]     s1_word;
  logic              s1_wst;
  logic [RUN_W-1:0]  s1_run [WORD_W];

  logic [LEN_W-1:0]  carry;
  logic [BASE_W-1:0] cstart;

  logic [WORD_W-1:0] ext;
  logic [WORD_W-1:0] hit;
  logic [TOT_W-1:0]  total [WORD_W];
  logic [BIT_W-1:0]  hidx;
  logic              found;
  logic [RUN_W-1:0]  jpos;
  logic [RUN_W-1:0]  tail;
  logic [UW-1:0]     unit_u;
  logic [UW-1:0]     tail_u;
  logic [BASE_W-1:0] base_at;

  // stage 1: free map of the word and the free run ending at each bit
  always_comb begin
    free_bits = ~data;
    if (32'(ctl.word) == 32'(rsv[BASE_W-1:BIT_W])) begin
      free_bits = free_bits & ({WORD_W{1'b1}} << rsv[BIT_W-1:0]);
    end
    if (32'(ctl.word) == 32'(WORDS - 1)) begin
      free_bits = free_bits & LAST_MASK;
    end
    for (int i = 0; i < WORD_W; i++) begin
      zpos[i] = '0;
      for (int j = 0; j <= i; j++) begin
        if (!free_bits[j]) begin
          zpos[i] = RUN_W'(j + 1);
        end
      end
      run_next[i] = RUN_W'(i + 1) - zpos[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= ctl.valid;
    end
    s1_word <= ctl.word;
    s1_wst  <= (32'(ctl.word) < 32'(BASE_WORDS));
    for (int i = 0; i < WORD_W; i++) begin
      s1_run[i] <= run_next[i];
    end
  end

  // stage 2: join with the run carried from earlier words, pick the first fit
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      ext[i] = (s1_run[i] == RUN_W'(i + 1));
      if (ext[i]) begin
        if (carry != '0) begin
          total[i] = TOT_W'(carry) + TOT_W'(i + 1);
        end else begin
          total[i] = s1_wst ? TOT_W'(i + 1) : '0;
        end
      end else begin
        total[i] = s1_wst ? TOT_W'(s1_run[i]) : '0;
      end
      hit[i] = (total[i] >= TOT_W'(len));
    end
    hidx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hidx = BIT_W'(i);
      end
    end
    found   = |hit;
    jpos    = RUN_W'(hidx) + RUN_W'(1) - s1_run[hidx];
    unit_u  = UW'({s1_word, jpos[BIT_W-1:0]});
    base_at = (ext[hidx] && carry != '0) ? cstart : unit_u[BASE_W-1:0];
    tail    = RUN_W'(WORD_W) - s1_run[WORD_W-1];
    tail_u  = UW'({s1_word, tail[BIT_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      carry <= '0;
    end else if (s1_v && !found) begin
      carry <= total[WORD_W-1][LEN_W-1:0];
    end
    if (s1_v && !found && !(ext[WORD_W-1] && carry != '0)) begin
      cstart <= tail_u[BASE_W-1:0];
    end
  end

  assign res.valid = s1_v;
  assign res.hit   = found;
  assign res.last  = (32'(s1_word) == 32'(WORDS - 1));
  assign res.base  = base_at;

endmodule
`default_nettype wire

>>> hw/rtl/bitmap_first_fit_allocator.sv
// First-fit segment allocator over a one-bit-per-unit occupancy map kept in a
// 32-bit-wide block RAM. An allocate scans one map word per cycle upward from
// the word holding the reserved bound rsv; when no run fits it answers with no
// space, and when one does it then marks the words the granted run spans. A
// free marks the words it spans; refused items go straight to the result. The
// scan rate is set by the single RAM read port. After reset a clearing pass
// writes every map word once (128 words for 4096 units) with busy held high;
// configuration writes are taken throughout. Each item gives exactly one
// result, shown for a single cycle on done; the receiver cannot stall it.
`default_nettype none
module bitmap_first_fit_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [bffa_pkg::LEN_W-1:0]    seg_length,
  input  logic [bffa_pkg::BASE_W-1:0]   seg_base,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [bffa_pkg::BASE_W-1:0]   granted_base,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bffa_pkg::BASE_W-1:0]   cfg_data
);
  import bffa_pkg::*;

  fsm_t              state;
  fsm_t              state_next;
  logic [AW-1:0]     addr;
  logic              pend;
  logic [AW-1:0]     pend_word;
  logic              op;
  logic [LEN_W-1:0]  len;
  logic [UW-1:0]     lo;
  logic [UW-1:0]     hi;
  logic [1:0]        stat;
  logic [BASE_W-1:0] gbase;
  logic [BASE_W-1:0] rsv;

  logic              accept;
  logic              issue;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] mask;
  logic [BIT_W-1:0]  lo_b;
  logic [BIT_W-1:0]  hi_b;
  logic [AW-1:0]     lo_word;
  logic [AW-1:0]     hi_word;
  logic [UW-1:0]     free_end;
  logic              bad_free;
  logic              rsv_full;
  logic [UW-1:0]     hit_lo;
  scan_ctl_t         sctl;
  scan_res_t         sres;

  assign accept   = start && !busy;
  assign lo_word  = lo[BIT_W +: AW];
  assign hi_word  = hi[BIT_W +: AW];
  assign free_end = UW'(seg_base) + UW'(seg_length);
  assign bad_free = (seg_length == '0) || (seg_base < rsv) || (free_end > UW'(MEMORY_UNITS));
  assign rsv_full = (UW'(rsv) >= UW'(MEMORY_UNITS));
  assign hit_lo   = UW'(sres.base);

  assign cfg_ready    = 1'b1;
  assign status       = stat;
  assign granted_base = gbase;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_ALLOC) begin
            state_next = (seg_length == '0 || rsv_full) ? ST_RESP : ST_SCAN;
          end else begin
            state_next = bad_free ? ST_RESP : ST_MARK;
          end
        end
      end
      ST_SCAN: begin
        if (sres.valid && sres.hit) begin
          state_next = ST_MARK;
        end else if (sres.valid && sres.last) begin
          state_next = ST_RESP;
        end
      end
      ST_MARK: begin
        if (pend && pend_word == hi_word) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    lo_b = (pend_word == lo_word) ? lo[BIT_W-1:0] : '0;
    hi_b = (pend_word == hi_word) ? hi[BIT_W-1:0] : '1;
    mask = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_b));
  end

  always_comb begin
    busy  = 1'b1;
    done  = 1'b0;
    issue = 1'b0;
    we    = 1'b0;
    waddr = pend_word;
    wdata = (op == OP_FREE) ? (rdata & ~mask) : (rdata | mask);
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = addr;
        wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        issue = (addr < AW'(WORDS));
      end
      ST_MARK: begin
        issue = (addr <= hi_word);
        we    = pend;
      end
      ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign sctl.clear = (state == ST_IDLE);
  assign sctl.valid = pend && (state == ST_SCAN);
  assign sctl.word  = pend_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
      pend  <= 1'b0;
      rsv   <= RESERVED_RESET;
    end else begin
      state <= state_next;
      pend  <= issue && (state_next == state);
      if (cfg_valid && cfg_ready) begin
        rsv <= cfg_data;
      end
      priority if (state == ST_CLEAR) begin
        addr <= addr + AW'(1);
      end else if (state == ST_IDLE && accept) begin
        addr <= (opcode == OP_ALLOC) ? AW'(rsv >> BIT_W) : AW'(seg_base >> BIT_W);
      end else if (state == ST_SCAN && sres.valid && sres.hit) begin
        addr <= AW'(sres.base >> BIT_W);
      end else if (issue) begin
        addr <= addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_word <= addr;
    if (state == ST_IDLE && accept) begin
      op    <= opcode;
      len   <= seg_length;
      lo    <= UW'(seg_base);
      hi    <= free_end - UW'(1);
      gbase <= '0;
      if (opcode == OP_ALLOC) begin
        stat <= STAT_NO_SPACE;
      end else begin
        stat <= bad_free ? STAT_BAD_FREE : STAT_DONE;
      end
    end else if (state == ST_SCAN && sres.valid && sres.hit) begin
      lo    <= hit_lo;
      hi    <= hit_lo + UW'(len) - UW'(1);
      stat  <= STAT_DONE;
      gbase <= sres.base;
    end
  end

  bffa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr[WADDR_W-1:0]),
    .wdata(wdata),
    .raddr(addr[WADDR_W-1:0]),
    .rdata(rdata)
  );

  bffa_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (sctl),
    .data(rdata),
    .len (len),
    .rsv (rsv),
    .res (sres)
  );

  a_refused_base_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_DONE) |-> (granted_base == '0))
    else $error("refused result carries a nonzero base");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && we) |-> (pend_word >= lo_word && pend_word <= hi_word))
    else $error("map write outside the segment");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item left the block idle");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown for more than one cycle");

endmodule
`default_nettype wire

>>> dv/bitmap_first_fit_allocator_tb.sv
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_tb;
  import bffa_pkg::*;

  localparam int MAX_BASE = (1 << BASE_W) - 1;

  typedef struct {
    logic [1:0]        status;
    logic [BASE_W-1:0] base;
  } outcome_t;

  typedef struct {
    int base;
    int len;
  } segment_t;

  class segment_scoreboard;
    bit                unit_used [MEMORY_UNITS];
    logic [BASE_W-1:0] reserved;
    outcome_t          awaited [$];
    int                errors;

    function new();
      reserved = RESERVED_RESET;
      errors   = 0;
      foreach (unit_used[k]) unit_used[k] = 1'b0;
    endfunction

    function outcome_t first_fit(int len);
      outcome_t res;
      int       run;
      int       first;
      run = 0;
      first = 0;
      res.status = STAT_NO_SPACE;
      res.base = '0;
      if (len == 0) return res;
      for (int u = int'(reserved); u < MEMORY_UNITS; u++) begin
        if (unit_used[u]) begin
          run = 0;
        end else begin
          if (run == 0) begin
            if (u > MAX_BASE) break;
            first = u;
          end
          run++;
          if (run == len) begin
            for (int k = first; k <= u; k++) unit_used[k] = 1'b1;
            res.status = STAT_DONE;
            res.base = first[BASE_W-1:0];
            return res;
          end
        end
      end
      return res;
    endfunction

    function outcome_t free_run(int base, int len);
      outcome_t res;
      res.base = '0;
      if (len == 0 || base < int'(reserved) || base + len > MEMORY_UNITS) begin
        res.status = STAT_BAD_FREE;
        return res;
      end
      for (int k = base; k < base + len; k++) unit_used[k] = 1'b0;
      res.status = STAT_DONE;
      return res;
    endfunction

    function outcome_t note_item(logic op, logic [LEN_W-1:0] len, logic [BASE_W-1:0] base);
      outcome_t res;
      if (op == OP_ALLOC) res = first_fit(int'(len));
      else res = free_run(int'(base), int'(len));
      awaited.push_back(res);
      return res;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] status, logic [BASE_W-1:0] base);
      outcome_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result status=%0d base=%0d with none awaited", status, base));
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, predicted %0d", status, want.status));
        if (base !== want.base)
          report($sformatf("granted_base %0d, predicted %0d", base, want.base));
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              opcode;
  logic [LEN_W-1:0]  seg_length;
  logic [BASE_W-1:0] seg_base;
  logic              done;
  logic [1:0]        status;
  logic [BASE_W-1:0] granted_base;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BASE_W-1:0] cfg_data;

  segment_scoreboard sb;
  segment_t          live_segs [$];
  int                sender_idle;

  bitmap_first_fit_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .seg_length   (seg_length),
    .seg_base     (seg_base),
    .done         (done),
    .status       (status),
    .granted_base (granted_base),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, granted_base);
  end

  task automatic pause_sender();
    while ($urandom_range(0, 99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_item(logic op, int len, int base);
    outcome_t res;
    pause_sender();
    start      <= 1'b1;
    opcode     <= op;
    seg_length <= len[LEN_W-1:0];
    seg_base   <= base[BASE_W-1:0];
    do @(posedge clk); while (busy);
    res = sb.note_item(op, len[LEN_W-1:0], base[BASE_W-1:0]);
    if (op == OP_ALLOC && res.status == STAT_DONE)
      live_segs.push_back('{int'(res.base), len});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.awaited.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reserved(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[BASE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.reserved = value[BASE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int       pick;
    int       len;
    int       idx;
    segment_t seg;
    pick = $urandom_range(0, 99);
    if (live_segs.size() > 120) pick = pick + 20;
    if (pick < 50) begin
      idx = $urandom_range(0, 99);
      if (idx < 80) len = $urandom_range(1, 24);
      else if (idx < 95) len = $urandom_range(25, 96);
      else len = $urandom_range(97, 255);
      send_item(OP_ALLOC, len, $urandom_range(0, MAX_BASE));
    end else if (pick < 88 && live_segs.size() > 0) begin
      idx = $urandom_range(0, live_segs.size() - 1);
      seg = live_segs[idx];
      live_segs.delete(idx);
      send_item(OP_FREE, seg.len, seg.base);
    end else if (pick % 5 == 0) begin
      send_item(OP_ALLOC, 0, $urandom_range(0, MAX_BASE));
    end else begin
      send_item(OP_FREE, $urandom_range(0, 255), $urandom_range(0, MAX_BASE));
    end
  endtask

  initial begin
    int stage_cfg [6];
    int stage_idle [6];
    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    opcode      = OP_ALLOC;
    seg_length  = '0;
    seg_base    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    sender_idle = 19;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_reserved(24);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 255, MAX_BASE);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_FREE, 0, 100);
    send_item(OP_FREE, 1, 23);
    send_item(OP_FREE, 2, MAX_BASE);
    send_item(OP_FREE, 1, MAX_BASE);
    send_item(OP_FREE, 255, 25);
    send_item(OP_ALLOC, 16, 0);
    send_item(OP_FREE, 1, 24);
    send_item(OP_FREE, 255, MEMORY_UNITS - 255);
    send_item(OP_FREE, 255, MEMORY_UNITS - 254);
    wait_idle();

    write_reserved(MAX_BASE);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 2, 0);
    send_item(OP_FREE, 1, MAX_BASE - 1);
    send_item(OP_FREE, 1, MAX_BASE);
    wait_idle();

    write_reserved(0);
    send_item(OP_FREE, 255, 0);
    send_item(OP_ALLOC, 1, 0);
    wait_idle();
    live_segs.delete();

    stage_cfg  = '{0, $urandom_range(1, MAX_BASE - 1), MAX_BASE, 24,
                   $urandom_range(2048, 4000), 300};
    stage_idle = '{19, 19, 86, 86, 0, 0};
    for (int s = 0; s < 6; s++) begin
      write_reserved(stage_cfg[s]);
      sender_idle = stage_idle[s];
      repeat (205) random_item();
      wait_idle();
    end

    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
